// ===== hdl/complex_number_alu_assert.svh =====
// Assertion macros for the complex arithmetic unit.
// Used by complex_number_alu.sv; expects clk and rst_n in scope.
`ifndef COMPLEX_NUMBER_ALU_ASSERT_SVH
`define COMPLEX_NUMBER_ALU_ASSERT_SVH

// same-cycle implication
`define CNA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CNA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cna_pkg.sv =====
// Shared types and constants for the complex arithmetic unit.
// No dependencies.
package cna_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int TOL_W         = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_CDIV = 3'd3,
    OP_EQ   = 3'd4,
    OP_SDIV = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // per-item control travelling along the pipe
  typedef struct packed {
    logic sgn_re;
    logic sgn_im;
    logic ovf_re;
    logic ovf_im;
    logic divz;
    logic eq;
    logic zero;
    logic div;
  } cna_ctrl_t;

endpackage

// ===== hdl/complex_number_alu.sv =====
// Complex arithmetic unit, signed fixed point, Q16.16 by default.
// Throughput: one transfer per cycle unless out_ready stalls the pipe; every stage has its own valid bit.
// The pipe is three front-end stages, WORD_BITS + 1 divider cells and the output register.
// Reset: rst_n synchronous, active low; empties the pipe, tolerance back to 66.
// Depends on cna_pkg, cna_front, cna_cell, cna_back, complex_number_alu_assert.svh.
module complex_number_alu #(
  parameter int WORD_BITS = cna_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cna_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [cna_pkg::TOL_W-1:0]   cfg_wdata,
  // operands
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_req_type,
  input  logic signed [WORD_BITS-1:0] in_a_re,
  input  logic signed [WORD_BITS-1:0] in_a_im,
  input  logic signed [WORD_BITS-1:0] in_b_re,
  input  logic signed [WORD_BITS-1:0] in_b_im,
  // results
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] out_res_re,
  output logic signed [WORD_BITS-1:0] out_res_im,
  output logic                        out_is_equal,
  output logic [1:0]                  out_status
);

  `include "complex_number_alu_assert.svh"

  localparam int W     = WORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int NUM_W = 2 * W + F;
  localparam int NCELL = W + 1;   // quotient bits W down to 0

  // equality tolerance register
  logic [cna_pkg::TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= cna_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // chain links; link 0 is the front end output, link NCELL feeds the back end
  logic               lk_valid [0:NCELL];
  logic               lk_ready [0:NCELL];
  cna_pkg::cna_ctrl_t lk_ctrl  [0:NCELL];
  logic [W:0]         lk_mag_re[0:NCELL];
  logic [W:0]         lk_mag_im[0:NCELL];
  logic [NUM_W-1:0]   lk_rem_re[0:NCELL];
  logic [NUM_W-1:0]   lk_rem_im[0:NCELL];
  logic [2*W-1:0]     lk_den   [0:NCELL];

  // products, decode, divider set-up and range check (three stages)
  cna_front #(.W(W), .F(F)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .tol         (tol_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_a_re     (in_a_re),
    .in_a_im     (in_a_im),
    .in_b_re     (in_b_re),
    .in_b_im     (in_b_im),
    .dn_valid    (lk_valid[0]),
    .dn_ready    (lk_ready[0]),
    .dn_ctrl     (lk_ctrl[0]),
    .dn_mag_re   (lk_mag_re[0]),
    .dn_mag_im   (lk_mag_im[0]),
    .dn_rem_re   (lk_rem_re[0]),
    .dn_rem_im   (lk_rem_im[0]),
    .dn_den      (lk_den[0])
  );

  // divider cells, most significant quotient bit first; non-divide
  // items ride through unchanged so order is kept
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    cna_cell #(.W(W), .F(F), .SHIFT(W - g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (lk_valid[g]),
      .up_ready  (lk_ready[g]),
      .up_ctrl   (lk_ctrl[g]),
      .up_mag_re (lk_mag_re[g]),
      .up_mag_im (lk_mag_im[g]),
      .up_rem_re (lk_rem_re[g]),
      .up_rem_im (lk_rem_im[g]),
      .up_den    (lk_den[g]),
      .dn_valid  (lk_valid[g+1]),
      .dn_ready  (lk_ready[g+1]),
      .dn_ctrl   (lk_ctrl[g+1]),
      .dn_mag_re (lk_mag_re[g+1]),
      .dn_mag_im (lk_mag_im[g+1]),
      .dn_rem_re (lk_rem_re[g+1]),
      .dn_rem_im (lk_rem_im[g+1]),
      .dn_den    (lk_den[g+1])
    );
  end

  // sign, saturation and output register; remainder and divisor end here
  cna_back #(.W(W)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (lk_valid[NCELL]),
    .up_ready     (lk_ready[NCELL]),
    .up_ctrl      (lk_ctrl[NCELL]),
    .up_mag_re    (lk_mag_re[NCELL]),
    .up_mag_im    (lk_mag_im[NCELL]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_res_re   (out_res_re),
    .out_res_im   (out_res_im),
    .out_is_equal (out_is_equal),
    .out_status   (out_status)
  );

  localparam logic [W-1:0] A_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] A_MIN = {1'b1, {(W-1){1'b0}}};

  // division by zero always returns a zero result
  `CNA_ASSERT_NOW(a_divz_zero, out_valid && (out_status == cna_pkg::ST_DIVZ),
    (out_res_re == '0) && (out_res_im == '0), "divide by zero with non-zero result")

  // an equality hit carries no result and no status
  `CNA_ASSERT_NOW(a_eq_clean, out_valid && out_is_equal,
    (out_status == cna_pkg::ST_OK) && (out_res_re == '0) && (out_res_im == '0),
    "equality flag with result or status")

  // saturation leaves at least one component on a rail
  `CNA_ASSERT_NOW(a_sat_rail, out_valid && (out_status == cna_pkg::ST_SAT),
    (out_res_re == A_MAX) || (out_res_re == A_MIN) ||
    (out_res_im == A_MAX) || (out_res_im == A_MIN),
    "saturation status without a clamped component")

  // a held result must not change under stall
  `CNA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_res_re) && $stable(out_res_im) && $stable(out_status),
    "result changed while stalled")

endmodule

// ===== hdl/cna_front.sv =====
// Front end: operand register with products, operation decode, divider setup
// and quotient range check. Depends on cna_pkg.
module cna_front #(
  parameter int W = cna_pkg::WORD_BITS_DEF,
  parameter int F = cna_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [cna_pkg::TOL_W-1:0] tol,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_req_type,
  input  logic signed [W-1:0]       in_a_re,
  input  logic signed [W-1:0]       in_a_im,
  input  logic signed [W-1:0]       in_b_re,
  input  logic signed [W-1:0]       in_b_im,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output cna_pkg::cna_ctrl_t        dn_ctrl,
  output logic [W:0]                dn_mag_re,
  output logic [W:0]                dn_mag_im,
  output logic [2*W+F-1:0]          dn_rem_re,
  output logic [2*W+F-1:0]          dn_rem_im,
  output logic [2*W-1:0]            dn_den
);

  localparam int PW    = 2 * W;
  localparam int NUM_W = 2 * W + F;
  localparam int CMP_W = 3 * W + F + 2;

  // stage 1: products and sums
  logic                  v1_r, rdy1, rdy2, rdy3, v2_r, v3_r;
  logic [2:0]            op1_r;
  logic signed [PW-1:0]  p_arbr_r, p_aibi_r, p_arbi_r, p_aibr_r, p_brbr_r, p_bibi_r;
  logic signed [W:0]     sum_re_r, sum_im_r;
  logic signed [W-1:0]   a_re1_r, a_im1_r, b_re1_r;
  logic signed [PW-1:0]  xa_re, xa_im, xb_re, xb_im;
  logic signed [W:0]     add_re, add_im, dif_re, dif_im;
  logic                  use_dif;

  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign xa_re = PW'(in_a_re);
  assign xa_im = PW'(in_a_im);
  assign xb_re = PW'(in_b_re);
  assign xb_im = PW'(in_b_im);
  assign add_re = (W+1)'(in_a_re) + (W+1)'(in_b_re);
  assign add_im = (W+1)'(in_a_im) + (W+1)'(in_b_im);
  assign dif_re = (W+1)'(in_a_re) - (W+1)'(in_b_re);
  assign dif_im = (W+1)'(in_a_im) - (W+1)'(in_b_im);
  assign use_dif = (in_req_type == cna_pkg::OP_SUB) || (in_req_type == cna_pkg::OP_EQ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      op1_r    <= in_req_type;
      p_arbr_r <= xa_re * xb_re;
      p_aibi_r <= xa_im * xb_im;
      p_arbi_r <= xa_re * xb_im;
      p_aibr_r <= xa_im * xb_re;
      p_brbr_r <= xb_re * xb_re;
      p_bibi_r <= xb_im * xb_im;
      sum_re_r <= use_dif ? dif_re : add_re;
      sum_im_r <= use_dif ? dif_im : add_im;
      a_re1_r  <= in_a_re;
      a_im1_r  <= in_a_im;
      b_re1_r  <= in_b_re;
    end
  end

  // stage 2: combine, decode
  cna_pkg::cna_ctrl_t   ctrl2_nxt, ctrl2_r;
  logic [W:0]           mag_re2_nxt, mag_im2_nxt, mag_re2_r, mag_im2_r;
  logic [NUM_W-1:0]     num_re2_nxt, num_im2_nxt, num_re2_r, num_im2_r;
  logic [PW-1:0]        den2_nxt, den2_r;
  logic signed [PW:0]   mr, mi, nr, ni, den_c;
  logic [PW:0]          mr_abs, mi_abs, nr_abs, ni_abs;
  logic [W:0]           s_re_abs, s_im_abs, d_re_abs, d_im_abs;
  logic [W-1:0]         ar_abs, ai_abs, br_abs;

  assign mr    = (PW+1)'(p_arbr_r) - (PW+1)'(p_aibi_r);
  assign mi    = (PW+1)'(p_arbi_r) + (PW+1)'(p_aibr_r);
  assign nr    = (PW+1)'(p_arbr_r) + (PW+1)'(p_aibi_r);
  assign ni    = (PW+1)'(p_aibr_r) - (PW+1)'(p_arbi_r);
  assign den_c = (PW+1)'(p_brbr_r) + (PW+1)'(p_bibi_r);

  assign mr_abs   = mr[PW] ? -mr : mr;
  assign mi_abs   = mi[PW] ? -mi : mi;
  assign nr_abs   = nr[PW] ? -nr : nr;
  assign ni_abs   = ni[PW] ? -ni : ni;
  assign s_re_abs = sum_re_r[W] ? -sum_re_r : sum_re_r;
  assign s_im_abs = sum_im_r[W] ? -sum_im_r : sum_im_r;
  assign d_re_abs = s_re_abs;
  assign d_im_abs = s_im_abs;
  assign ar_abs   = a_re1_r[W-1] ? -a_re1_r : a_re1_r;
  assign ai_abs   = a_im1_r[W-1] ? -a_im1_r : a_im1_r;
  assign br_abs   = b_re1_r[W-1] ? -b_re1_r : b_re1_r;

  always_comb begin
    ctrl2_nxt   = '0;
    mag_re2_nxt = '0;
    mag_im2_nxt = '0;
    num_re2_nxt = '0;
    num_im2_nxt = '0;
    den2_nxt    = '0;
    unique case (op1_r)
      cna_pkg::OP_ADD, cna_pkg::OP_SUB: begin
        ctrl2_nxt.sgn_re = sum_re_r[W];
        ctrl2_nxt.sgn_im = sum_im_r[W];
        mag_re2_nxt      = s_re_abs;
        mag_im2_nxt      = s_im_abs;
      end
      cna_pkg::OP_MUL: begin
        ctrl2_nxt.sgn_re = mr[PW];
        ctrl2_nxt.sgn_im = mi[PW];
        ctrl2_nxt.ovf_re = (mr_abs >> (F + W + 1)) != '0;
        ctrl2_nxt.ovf_im = (mi_abs >> (F + W + 1)) != '0;
        mag_re2_nxt      = (W+1)'(mr_abs >> F);
        mag_im2_nxt      = (W+1)'(mi_abs >> F);
      end
      cna_pkg::OP_CDIV: begin
        ctrl2_nxt.div    = 1'b1;
        ctrl2_nxt.divz   = (den_c == '0);
        ctrl2_nxt.zero   = (den_c == '0);
        ctrl2_nxt.sgn_re = nr[PW];
        ctrl2_nxt.sgn_im = ni[PW];
        num_re2_nxt      = {nr_abs[PW-1:0], {F{1'b0}}};
        num_im2_nxt      = {ni_abs[PW-1:0], {F{1'b0}}};
        den2_nxt         = den_c[PW-1:0];
      end
      cna_pkg::OP_EQ: begin
        ctrl2_nxt.zero = 1'b1;
        ctrl2_nxt.eq   = (d_re_abs <= (W+1)'(tol)) && (d_im_abs <= (W+1)'(tol));
      end
      cna_pkg::OP_SDIV: begin
        ctrl2_nxt.div    = 1'b1;
        ctrl2_nxt.divz   = (b_re1_r == '0);
        ctrl2_nxt.zero   = (b_re1_r == '0);
        ctrl2_nxt.sgn_re = a_re1_r[W-1] ^ b_re1_r[W-1];
        ctrl2_nxt.sgn_im = a_im1_r[W-1] ^ b_re1_r[W-1];
        num_re2_nxt      = NUM_W'({ar_abs, {F{1'b0}}});
        num_im2_nxt      = NUM_W'({ai_abs, {F{1'b0}}});
        den2_nxt         = PW'(br_abs);
      end
      default: begin
        ctrl2_nxt.zero = 1'b1;
      end
    endcase
  end

  assign rdy2 = !v2_r || rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      ctrl2_r   <= ctrl2_nxt;
      mag_re2_r <= mag_re2_nxt;
      mag_im2_r <= mag_im2_nxt;
      num_re2_r <= num_re2_nxt;
      num_im2_r <= num_im2_nxt;
      den2_r    <= den2_nxt;
    end
  end

  // stage 3: quotient at or above 2^(W+1) saturates regardless
  cna_pkg::cna_ctrl_t ctrl3_nxt, ctrl3_r;
  logic [CMP_W-1:0]   den_top;
  logic [W:0]         mag_re3_r, mag_im3_r;
  logic [NUM_W-1:0]   num_re3_r, num_im3_r;
  logic [PW-1:0]      den3_r;

  assign den_top = CMP_W'(den2_r) << (W + 1);

  always_comb begin
    ctrl3_nxt = ctrl2_r;
    if (ctrl2_r.div && (CMP_W'(num_re2_r) >= den_top)) begin
      ctrl3_nxt.ovf_re = 1'b1;
    end
    if (ctrl2_r.div && (CMP_W'(num_im2_r) >= den_top)) begin
      ctrl3_nxt.ovf_im = 1'b1;
    end
  end

  assign rdy3 = !v3_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      ctrl3_r   <= ctrl3_nxt;
      mag_re3_r <= mag_re2_r;
      mag_im3_r <= mag_im2_r;
      num_re3_r <= num_re2_r;
      num_im3_r <= num_im2_r;
      den3_r    <= den2_r;
    end
  end

  assign dn_valid  = v3_r;
  assign dn_ctrl   = ctrl3_r;
  assign dn_mag_re = mag_re3_r;
  assign dn_mag_im = mag_im3_r;
  assign dn_rem_re = num_re3_r;
  assign dn_rem_im = num_im3_r;
  assign dn_den    = den3_r;

endmodule

// ===== hdl/cna_cell.sv =====
// One restoring-division cell: settles quotient bit SHIFT of both lanes.
// Depends on cna_pkg.
module cna_cell #(
  parameter int W     = cna_pkg::WORD_BITS_DEF,
  parameter int F     = cna_pkg::FRAC_BITS_DEF,
  parameter int SHIFT = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  cna_pkg::cna_ctrl_t up_ctrl,
  input  logic [W:0]         up_mag_re,
  input  logic [W:0]         up_mag_im,
  input  logic [2*W+F-1:0]   up_rem_re,
  input  logic [2*W+F-1:0]   up_rem_im,
  input  logic [2*W-1:0]     up_den,
  output logic               dn_valid,
  input  logic               dn_ready,
  output cna_pkg::cna_ctrl_t dn_ctrl,
  output logic [W:0]         dn_mag_re,
  output logic [W:0]         dn_mag_im,
  output logic [2*W+F-1:0]   dn_rem_re,
  output logic [2*W+F-1:0]   dn_rem_im,
  output logic [2*W-1:0]     dn_den
);

  localparam int NUM_W = 2 * W + F;
  localparam int CMP_W = 3 * W + F + 2;

  logic               v_r;
  cna_pkg::cna_ctrl_t ctrl_r;
  logic [W:0]         mag_re_r, mag_im_r, mag_re_nxt, mag_im_nxt;
  logic [NUM_W-1:0]   rem_re_r, rem_im_r, rem_re_nxt, rem_im_nxt;
  logic [2*W-1:0]     den_r;
  logic [CMP_W-1:0]   dsh, r_re, r_im;
  logic               ge_re, ge_im;

  assign dsh   = CMP_W'(up_den) << SHIFT;
  assign r_re  = CMP_W'(up_rem_re);
  assign r_im  = CMP_W'(up_rem_im);
  assign ge_re = up_ctrl.div && (r_re >= dsh);
  assign ge_im = up_ctrl.div && (r_im >= dsh);

  always_comb begin
    mag_re_nxt = up_mag_re;
    mag_im_nxt = up_mag_im;
    rem_re_nxt = up_rem_re;
    rem_im_nxt = up_rem_im;
    if (ge_re) begin
      mag_re_nxt[SHIFT] = 1'b1;
      rem_re_nxt        = NUM_W'(r_re - dsh);
    end
    if (ge_im) begin
      mag_im_nxt[SHIFT] = 1'b1;
      rem_im_nxt        = NUM_W'(r_im - dsh);
    end
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ctrl_r   <= up_ctrl;
      mag_re_r <= mag_re_nxt;
      mag_im_r <= mag_im_nxt;
      rem_re_r <= rem_re_nxt;
      rem_im_r <= rem_im_nxt;
      den_r    <= up_den;
    end
  end

  assign dn_valid  = v_r;
  assign dn_ctrl   = ctrl_r;
  assign dn_mag_re = mag_re_r;
  assign dn_mag_im = mag_im_r;
  assign dn_rem_re = rem_re_r;
  assign dn_rem_im = rem_im_r;
  assign dn_den    = den_r;

endmodule

// ===== hdl/cna_back.sv =====
// Back end: sign restore, saturation, status and the output register.
// Depends on cna_pkg.
module cna_back #(
  parameter int W = cna_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  cna_pkg::cna_ctrl_t up_ctrl,
  input  logic [W:0]         up_mag_re,
  input  logic [W:0]         up_mag_im,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [W-1:0] out_res_re,
  output logic signed [W-1:0] out_res_im,
  output logic               out_is_equal,
  output logic [1:0]         out_status
);

  localparam logic [W:0]   LIM_POS = {2'b00, {(W-1){1'b1}}};
  localparam logic [W:0]   LIM_NEG = {2'b01, {(W-1){1'b0}}};
  localparam logic [W-1:0] V_MAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] V_MIN   = {1'b1, {(W-1){1'b0}}};

  logic         sat_re, sat_im;
  logic [W-1:0] val_re, val_im;
  logic [W:0]   neg_re, neg_im;

  logic               valid_r, eq_r;
  logic [W-1:0]       re_r, im_r;
  logic [1:0]         st_r, st_nxt;

  assign neg_re = -up_mag_re;
  assign neg_im = -up_mag_im;

  assign sat_re = !up_ctrl.zero && (up_ctrl.ovf_re ||
                  (up_ctrl.sgn_re ? (up_mag_re > LIM_NEG) : (up_mag_re > LIM_POS)));
  assign sat_im = !up_ctrl.zero && (up_ctrl.ovf_im ||
                  (up_ctrl.sgn_im ? (up_mag_im > LIM_NEG) : (up_mag_im > LIM_POS)));

  always_comb begin
    if (up_ctrl.zero) begin
      val_re = '0;
    end else if (sat_re) begin
      val_re = up_ctrl.sgn_re ? V_MIN : V_MAX;
    end else begin
      val_re = up_ctrl.sgn_re ? neg_re[W-1:0] : up_mag_re[W-1:0];
    end
    if (up_ctrl.zero) begin
      val_im = '0;
    end else if (sat_im) begin
      val_im = up_ctrl.sgn_im ? V_MIN : V_MAX;
    end else begin
      val_im = up_ctrl.sgn_im ? neg_im[W-1:0] : up_mag_im[W-1:0];
    end
    priority if (up_ctrl.divz) begin
      st_nxt = cna_pkg::ST_DIVZ;
    end else if (sat_re || sat_im) begin
      st_nxt = cna_pkg::ST_SAT;
    end else begin
      st_nxt = cna_pkg::ST_OK;
    end
  end

  assign up_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      re_r <= val_re;
      im_r <= val_im;
      eq_r <= up_ctrl.eq;
      st_r <= st_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign out_res_re   = re_r;
  assign out_res_im   = im_r;
  assign out_is_equal = eq_r;
  assign out_status   = st_r;

endmodule

// ===== verif/complex_number_alu_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for complex_number_alu: directed and random operand transfers.
// Depends on cna_pkg and the complex_number_alu RTL; predicts each result in a scoreboard.
module complex_number_alu_test;

  localparam int  W          = cna_pkg::WORD_BITS_DEF;
  localparam int  F          = cna_pkg::FRAC_BITS_DEF;
  localparam int  LATENCY    = W + 5;
  localparam int  RAND_ITEMS = 1050;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [W-1:0] res_re;
    logic signed [W-1:0] res_im;
    logic                is_equal;
    logic [1:0]          status;
  } alu_result_t;

  // Predicts results from the operands and holds them in transfer order.
  class alu_scoreboard;
    alu_result_t               pending[$];
    logic [cna_pkg::TOL_W-1:0] tolerance;
    int                        errors;

    function new();
      tolerance = cna_pkg::TOL_RESET;
      errors    = 0;
    endfunction

    // clamp one component to the word range, raising the saturation flag
    function logic signed [W-1:0] clamp(input logic signed [127:0] x, output bit hit);
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = (128'sd1 <<< (W-1)) - 1;
      lo_lim = -(128'sd1 <<< (W-1));
      hit = 1'b0;
      if (x > hi_lim) begin
        hit = 1'b1;
        return hi_lim[W-1:0];
      end
      if (x < lo_lim) begin
        hit = 1'b1;
        return lo_lim[W-1:0];
      end
      return x[W-1:0];
    endfunction

    function void note_operands(input logic [2:0] op, input logic signed [W-1:0] a_re,
                                input logic signed [W-1:0] a_im,
                                input logic signed [W-1:0] b_re,
                                input logic signed [W-1:0] b_im);
      logic signed [127:0] ar, ai, br, bi, rr, ri, den, nr, ni, dr, di, tol;
      alu_result_t r;
      bit produce, s1, s2;
      ar = a_re; ai = a_im; br = b_re; bi = b_im;
      rr = 0; ri = 0;
      r = '0;
      produce = 1'b1;
      tol = {112'd0, tolerance};
      case (op)
        cna_pkg::OP_ADD: begin
          rr = ar + br; ri = ai + bi;
        end
        cna_pkg::OP_SUB: begin
          rr = ar - br; ri = ai - bi;
        end
        cna_pkg::OP_MUL: begin
          // division truncates toward zero, as the scaling does
          rr = (ar * br - ai * bi) / (128'sd1 <<< F);
          ri = (ar * bi + ai * br) / (128'sd1 <<< F);
        end
        cna_pkg::OP_CDIV: begin
          den = br * br + bi * bi;
          if (den == 0) begin
            r.status = cna_pkg::ST_DIVZ; produce = 1'b0;
          end else begin
            nr = ar * br + ai * bi;
            ni = ai * br - ar * bi;
            rr = (nr <<< F) / den;
            ri = (ni <<< F) / den;
          end
        end
        cna_pkg::OP_EQ: begin
          dr = ar - br; di = ai - bi;
          if (dr < 0) dr = -dr;
          if (di < 0) di = -di;
          r.is_equal = (dr <= tol) && (di <= tol);
          produce = 1'b0;
        end
        cna_pkg::OP_SDIV: begin
          if (br == 0) begin
            r.status = cna_pkg::ST_DIVZ; produce = 1'b0;
          end else begin
            rr = (ar <<< F) / br;
            ri = (ai <<< F) / br;
          end
        end
        default: produce = 1'b0;
      endcase
      if (produce) begin
        r.res_re = clamp(rr, s1);
        r.res_im = clamp(ri, s2);
        if (s1 || s2) r.status = cna_pkg::ST_SAT;
      end
      pending.push_back(r);
    endfunction

    function void check_result(input alu_result_t got);
      alu_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d eq=%0b st=%0d", $realtime,
                 got.res_re, got.res_im, got.is_equal, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.res_re !== want.res_re) begin
        $display("%0t: res_re expected %0d actual %0d", $realtime, want.res_re, got.res_re);
        errors++;
      end
      if (got.res_im !== want.res_im) begin
        $display("%0t: res_im expected %0d actual %0d", $realtime, want.res_im, got.res_im);
        errors++;
      end
      if (got.is_equal !== want.is_equal) begin
        $display("%0t: is_equal expected %0b actual %0b", $realtime, want.is_equal,
                 got.is_equal);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [cna_pkg::TOL_W-1:0] cfg_wdata;
  logic                      in_valid;
  logic                      in_ready;
  logic [2:0]                in_req_type;
  logic signed [W-1:0]       in_a_re, in_a_im, in_b_re, in_b_im;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [W-1:0]       out_res_re, out_res_im;
  logic                      out_is_equal;
  logic [1:0]                out_status;

  alu_scoreboard scb = new();
  longint        cycle_count = 0;

  complex_number_alu #(.WORD_BITS(W), .FRAC_BITS(F)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_a_re      (in_a_re),
    .in_a_im      (in_a_im),
    .in_b_re      (in_b_re),
    .in_b_im      (in_b_im),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_res_re   (out_res_re),
    .out_res_im   (out_res_im),
    .out_is_equal (out_is_equal),
    .out_status   (out_status)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // cycle counter doubles as the watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // mostly short idles, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // result side: random back-pressure, changed at the falling edge
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ready = 1'b1;
      n = $urandom_range(30, 1);
      repeat (n) @(negedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // result transfers are checked against the oldest prediction
  always @(posedge clk) begin
    alu_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.res_re   = out_res_re;
      got.res_im   = out_res_im;
      got.is_equal = out_is_equal;
      got.status   = out_status;
      scb.check_result(got);
    end
  end

  // one operand transfer; valid held until accepted, then a random idle gap, possibly none
  task automatic send_operands(input logic [2:0] op, input logic signed [W-1:0] ar,
                               input logic signed [W-1:0] ai,
                               input logic signed [W-1:0] br,
                               input logic signed [W-1:0] bi);
    int gap;
    @(negedge clk);
    in_valid    = 1'b1;
    in_req_type = op;
    in_a_re = ar; in_a_im = ai; in_b_re = br; in_b_im = bi;
    do @(posedge clk); while (!in_ready);
    scb.note_operands(op, ar, ai, br, bi);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // sender holds off until the pipe has drained
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (scb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 3) @(negedge clk);
  endtask

  // tolerance write, only ever issued with the pipe empty
  task automatic write_tolerance(input logic [cna_pkg::TOL_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    scb.tolerance = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // operand mix: full range, small values, and the extremes
  function automatic logic signed [W-1:0] rand_word();
    int p;
    p = $urandom_range(99);
    if (p < 35) return $urandom();
    if (p < 70) return $signed($urandom_range(2 * 65536 * 8)) - 65536 * 8;
    if (p < 80) return $signed($urandom_range(511)) - 256;
    case ($urandom_range(4))
      0: return 0;
      1: return {1'b0, {(W-1){1'b1}}};
      2: return {1'b1, {(W-1){1'b0}}};
      3: return 32'sd65536;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic send_random();
    logic [2:0]          op;
    logic signed [W-1:0] ar, ai, br, bi;
    int                  p;
    op = $urandom_range(99) < 94 ? 3'($urandom_range(5)) : 3'($urandom_range(7, 6));
    ar = rand_word(); ai = rand_word(); br = rand_word(); bi = rand_word();
    p = $urandom_range(99);
    // equality tests mostly near the tolerance edge
    if (op == cna_pkg::OP_EQ && p < 70) begin
      br = ar + $signed($urandom_range(2 * scb.tolerance + 4)) - scb.tolerance - 2;
      bi = ai + $signed($urandom_range(2 * scb.tolerance + 4)) - scb.tolerance - 2;
    end
    // a share of zero divisors
    if ((op == cna_pkg::OP_CDIV || op == cna_pkg::OP_SDIV) && p < 8) begin
      br = 0;
      if (op == cna_pkg::OP_CDIV) bi = 0;
    end
    send_operands(op, ar, ai, br, bi);
  endtask

  initial begin
    logic signed [W-1:0]       mx, mn;
    logic [cna_pkg::TOL_W-1:0] tols[4];
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    in_valid = 1'b0; in_req_type = cna_pkg::OP_ADD;
    in_a_re = '0; in_a_im = '0; in_b_re = '0; in_b_im = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, every operation, zero divisors, unused codes
    send_operands(cna_pkg::OP_ADD,  mx, mn, mx, mn);
    send_operands(cna_pkg::OP_ADD,  32'sd65536, -32'sd65536, 32'sd1, -32'sd1);
    send_operands(cna_pkg::OP_SUB,  mn, mx, mx, mn);
    send_operands(cna_pkg::OP_SUB,  32'sd5, 32'sd7, 32'sd5, 32'sd7);
    send_operands(cna_pkg::OP_MUL,  mx, mx, mx, mn);
    send_operands(cna_pkg::OP_MUL,  32'sd65536, 32'sd131072, -32'sd98304, 32'sd3);
    send_operands(cna_pkg::OP_MUL,  mn, mn, mn, mn);
    send_operands(cna_pkg::OP_CDIV, 32'sd65536, 32'sd65536, 32'sd0, 32'sd0);
    send_operands(cna_pkg::OP_CDIV, mx, mn, 32'sd1, 32'sd0);
    send_operands(cna_pkg::OP_CDIV, 32'sd196608, -32'sd65536, 32'sd65536, 32'sd131072);
    send_operands(cna_pkg::OP_CDIV, mn, mn, mn, mn);
    send_operands(cna_pkg::OP_SDIV, 32'sd65536, 32'sd65536, 32'sd0, 32'sd12345);
    send_operands(cna_pkg::OP_SDIV, mx, mn, 32'sd1, 32'sd0);
    send_operands(cna_pkg::OP_SDIV, -32'sd100000, 32'sd7, -32'sd3, mx);
    send_operands(cna_pkg::OP_SDIV, mn, mn, -32'sd65536, mn);
    send_operands(cna_pkg::OP_EQ,   32'sd1000, 32'sd1000, 32'sd1066, 32'sd934);
    send_operands(cna_pkg::OP_EQ,   32'sd1000, 32'sd1000, 32'sd1067, 32'sd1000);
    send_operands(cna_pkg::OP_EQ,   mx, mn, mn, mx);
    send_operands(3'd6,             mx, mn, 32'sd1, 32'sd1);
    send_operands(3'd7,             32'sd5, 32'sd5, 32'sd0, 32'sd0);

    // random phases over several tolerances, extremes included
    tols[0] = 16'd0; tols[1] = 16'hFFFF; tols[2] = cna_pkg::TOL_RESET;
    tols[3] = cna_pkg::TOL_W'($urandom());
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_tolerance(tols[ph]);
      for (int i = 0; i < RAND_ITEMS / 4; i++) send_random();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (scb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (scb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
